>>> src/rpc_frame_deframer_top_macros.svh
// Assertion helpers for the deframer.
`ifndef RPC_FRAME_DEFRAMER_TOP_MACROS_SVH
`define RPC_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rfd_pkg.sv
`default_nettype none

package rfd_pkg;

	// queue geometry shared by the front and result queues
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	// start mark + length + three prefixes + error code + end mark
	localparam logic [31:0] FIXED_BYTES = 32'd22;

	// field tags
	localparam logic [2:0] TAG_SKIP    = 3'd0;
	localparam logic [2:0] TAG_LEN     = 3'd1;
	localparam logic [2:0] TAG_MSG_ID  = 3'd2;
	localparam logic [2:0] TAG_METHOD  = 3'd3;
	localparam logic [2:0] TAG_ERRCODE = 3'd4;
	localparam logic [2:0] TAG_ERRTEXT = 3'd5;
	localparam logic [2:0] TAG_PAYLOAD = 3'd6;
	localparam logic [2:0] TAG_END     = 3'd7;

	// frame status
	localparam logic [1:0] STAT_BUSY    = 2'd0;
	localparam logic [1:0] STAT_GOOD    = 2'd1;
	localparam logic [1:0] STAT_BAD_END = 2'd2;
	localparam logic [1:0] STAT_LEN_ERR = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_START_BYTE = 2'd0;
	localparam logic [1:0] REG_END_BYTE   = 2'd1;
	localparam logic [1:0] REG_MAX_LEN    = 2'd2;

	// classified byte, front to parser
	typedef struct packed {
		logic [7:0] data;
		logic       is_start;
		logic       is_end;
	} item_t;

	// one result beat, parser to result queue
	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] field_tag;
		logic       frame_last;
		logic [1:0] frame_status;
	} result_t;

endpackage

`default_nettype wire

>>> src/rpc_frame_deframer_top.sv
`default_nettype none

// Streaming deframer for length-prefixed RPC frames. Bytes go in through a
// queue-style port (push/full) and come back out, one result beat per byte,
// through a second queue-style port (empty/pop), each tagged with the frame
// field it belongs to; the byte that closes or aborts a frame carries
// frame_last and a status (good, bad end mark, length error). Throughput is
// one byte per clock unless the front queue is empty or the result queue is
// full; each byte is registered in the front queue and then in the result
// queue. Both sides hold four beats, so either side may stall for a while
// without stopping the other. The frame length is checked against
// FIXED_BYTES, max_frame_len and the counter width LEN_BITS, string lengths
// against the bytes left in the frame; after any error the block goes back
// to hunting for the start mark with the next byte. Configuration writes are
// always taken (cfg_ready is held high) and should only be issued while no
// bytes are in flight; an index past the last register is ignored.
module rpc_frame_deframer_top #(
	parameter int LEN_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte input
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	// result output
	input  wire logic        pop,
	output logic             empty,
	output logic [7:0]       out_byte,
	output logic [2:0]       field_tag,
	output logic             frame_last,
	output logic [1:0]       frame_status,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	`include "rpc_frame_deframer_top_macros.svh"

	logic [7:0]        start_byte_q;
	logic [7:0]        end_byte_q;
	logic [23:0]       max_len_q;

	logic              front_empty;
	logic              front_pop;
	rfd_pkg::item_t    front_item;

	logic              res_full;
	logic              res_push;
	rfd_pkg::result_t  res;
	logic [$bits(rfd_pkg::result_t)-1:0] head_vec;
	rfd_pkg::result_t  head;

	// config registers; each write is registered straight into its register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= 8'd2;
			end_byte_q   <= 8'd3;
			max_len_q    <= 24'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rfd_pkg::REG_START_BYTE: start_byte_q <= cfg_data[7:0];
				rfd_pkg::REG_END_BYTE:   end_byte_q   <= cfg_data[7:0];
				rfd_pkg::REG_MAX_LEN:    max_len_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: mark compare and input queue
	rfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.full      (full),
		.start_byte(start_byte_q),
		.end_byte  (end_byte_q),
		.pop       (front_pop),
		.empty     (front_empty),
		.item      (front_item)
	);

	// back: frame layout walk
	rfd_parser #(
		.LEN_BITS(LEN_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_empty     (front_empty),
		.item         (front_item),
		.in_pop       (front_pop),
		.out_full     (res_full),
		.res_push     (res_push),
		.res          (res),
		.max_frame_len(max_len_q)
	);

	// result queue
	rfd_fifo #(
		.WIDTH($bits(rfd_pkg::result_t))
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(head_vec),
		.empty  (empty)
	);

	assign head         = rfd_pkg::result_t'(head_vec);
	assign out_byte     = head.out_byte;
	assign field_tag    = head.field_tag;
	assign frame_last   = head.frame_last;
	assign frame_status = head.frame_status;

	// a status only rides on a closing beat
	`RFD_ASSERT_NOW(a_status_on_last, res_push && !res.frame_last,
		res.frame_status == rfd_pkg::STAT_BUSY, "status set on a non-closing beat")
	// good or bad end mark verdicts only on the end-mark beat
	`RFD_ASSERT_NOW(a_end_verdict_tag,
		res_push && (res.frame_status == rfd_pkg::STAT_GOOD
		|| res.frame_status == rfd_pkg::STAT_BAD_END),
		res.field_tag == rfd_pkg::TAG_END, "end verdict off the end-mark beat")
	// skipped bytes never close a frame
	`RFD_ASSERT_NOW(a_skip_not_last, res_push && res.field_tag == rfd_pkg::TAG_SKIP,
		!res.frame_last, "skipped byte marked as frame end")
	// no result appears without a parser beat
	`RFD_ASSERT_NEXT(a_no_phantom, empty && !res_push, empty, "result beat out of nowhere")

endmodule

`default_nettype wire

>>> src/rfd_fifo.sv
`default_nettype none

module rfd_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	logic [WIDTH-1:0]             mem_q [rfd_pkg::QUEUE_DEPTH];
	logic [rfd_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [rfd_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [rfd_pkg::QUEUE_AW:0]   count_q;
	logic                         do_wr;
	logic                         do_rd;

	assign full    = (count_q == (rfd_pkg::QUEUE_AW+1)'(rfd_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/rfd_front.sv
`default_nettype none

// Front end: tags each received byte against the start and end marks
// and parks it in a short queue ahead of the parser.
module rfd_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] data_byte,
	output logic            full,
	input  wire logic [7:0] start_byte,
	input  wire logic [7:0] end_byte,
	input  wire logic       pop,
	output logic            empty,
	output rfd_pkg::item_t  item
);

	rfd_pkg::item_t                  in_item;
	logic [$bits(rfd_pkg::item_t)-1:0] head_vec;

	always_comb begin
		in_item.data     = data_byte;
		in_item.is_start = (data_byte == start_byte);
		in_item.is_end   = (data_byte == end_byte);
	end

	rfd_fifo #(
		.WIDTH($bits(rfd_pkg::item_t))
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(in_item),
		.full   (full),
		.rd_en  (pop),
		.rd_data(head_vec),
		.empty  (empty)
	);

	assign item = rfd_pkg::item_t'(head_vec);

endmodule

`default_nettype wire

>>> src/rfd_parser.sv
`default_nettype none

// Back end: walks the frame layout one byte per beat.
module rfd_parser #(
	parameter int LEN_BITS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_empty,
	input  wire rfd_pkg::item_t  item,
	output logic                 in_pop,
	input  wire logic            out_full,
	output logic                 res_push,
	output rfd_pkg::result_t     res,
	input  wire logic [23:0]     max_frame_len
);

	typedef enum logic [3:0] {
		PH_HUNT,
		PH_FLEN,
		PH_IDLEN,
		PH_ID,
		PH_METHLEN,
		PH_METH,
		PH_ERRCODE,
		PH_ERRLEN,
		PH_ERRTXT,
		PH_PAYLOAD,
		PH_END
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [LEN_BITS-1:0] left_q, left_d;   // bytes left in current field
	logic [LEN_BITS-1:0] free_q, free_d;   // frame bytes not yet claimed
	logic [23:0]         acc_q, acc_d;     // earlier bytes of a length field
	logic                fire;
	logic                cnt_last;
	logic [31:0]         len32;
	logic [LEN_BITS-1:0] len_n;
	logic [LEN_BITS-1:0] rem;
	logic                flen_bad;
	logic                str_bad;

	assign fire     = !in_empty && !out_full;
	assign in_pop   = fire;
	assign res_push = fire;

	assign cnt_last = (left_q == LEN_BITS'(1));
	assign len32    = {acc_q, item.data};
	assign len_n    = len32[LEN_BITS-1:0];
	assign rem      = free_q - len_n;
	assign flen_bad = (len32 < rfd_pkg::FIXED_BYTES) || (len32 > 32'(max_frame_len))
		|| ((len32 >> LEN_BITS) != 32'd0);
	assign str_bad  = (len32 > 32'(free_q));

	always_comb begin
		phase_d          = phase_q;
		left_d           = left_q - 1'b1;
		free_d           = free_q;
		acc_d            = acc_q;
		res.out_byte     = item.data;
		res.field_tag    = rfd_pkg::TAG_SKIP;
		res.frame_last   = 1'b0;
		res.frame_status = rfd_pkg::STAT_BUSY;
		unique case (phase_q)
			PH_HUNT: begin
				left_d = left_q;
				if (item.is_start) begin
					res.field_tag = rfd_pkg::TAG_LEN;
					phase_d       = PH_FLEN;
					left_d        = LEN_BITS'(4);
				end
			end
			PH_FLEN, PH_IDLEN, PH_METHLEN, PH_ERRLEN: begin
				res.field_tag = rfd_pkg::TAG_LEN;
				acc_d         = {acc_q[15:0], item.data};
				if (cnt_last) begin
					left_d = LEN_BITS'(4);
					if ((phase_q == PH_FLEN) ? flen_bad : str_bad) begin
						res.frame_last   = 1'b1;
						res.frame_status = rfd_pkg::STAT_LEN_ERR;
						phase_d          = PH_HUNT;
						left_d           = '0;
					end else if (phase_q == PH_FLEN) begin
						free_d  = len_n - LEN_BITS'(rfd_pkg::FIXED_BYTES);
						phase_d = PH_IDLEN;
					end else if (phase_q == PH_IDLEN) begin
						free_d = rem;
						if (len_n == '0) begin
							phase_d = PH_METHLEN;
						end else begin
							phase_d = PH_ID;
							left_d  = len_n;
						end
					end else if (phase_q == PH_METHLEN) begin
						free_d = rem;
						if (len_n == '0) begin
							phase_d = PH_ERRCODE;
						end else begin
							phase_d = PH_METH;
							left_d  = len_n;
						end
					end else begin
						free_d = rem;
						if (len_n != '0) begin
							phase_d = PH_ERRTXT;
							left_d  = len_n;
						end else if (rem == '0) begin
							phase_d = PH_END;
						end else begin
							phase_d = PH_PAYLOAD;
							left_d  = rem;
						end
					end
				end
			end
			PH_ID: begin
				res.field_tag = rfd_pkg::TAG_MSG_ID;
				if (cnt_last) begin
					phase_d = PH_METHLEN;
					left_d  = LEN_BITS'(4);
				end
			end
			PH_METH: begin
				res.field_tag = rfd_pkg::TAG_METHOD;
				if (cnt_last) begin
					phase_d = PH_ERRCODE;
					left_d  = LEN_BITS'(4);
				end
			end
			PH_ERRCODE: begin
				res.field_tag = rfd_pkg::TAG_ERRCODE;
				if (cnt_last) begin
					phase_d = PH_ERRLEN;
					left_d  = LEN_BITS'(4);
				end
			end
			PH_ERRTXT: begin
				res.field_tag = rfd_pkg::TAG_ERRTEXT;
				if (cnt_last) begin
					if (free_q == '0) begin
						phase_d = PH_END;
					end else begin
						phase_d = PH_PAYLOAD;
						left_d  = free_q;
					end
				end
			end
			PH_PAYLOAD: begin
				res.field_tag = rfd_pkg::TAG_PAYLOAD;
				if (cnt_last) begin
					phase_d = PH_END;
				end
			end
			PH_END: begin
				res.field_tag    = rfd_pkg::TAG_END;
				res.frame_last   = 1'b1;
				res.frame_status = item.is_end ? rfd_pkg::STAT_GOOD : rfd_pkg::STAT_BAD_END;
				phase_d          = PH_HUNT;
				left_d           = '0;
			end
			default: begin
				phase_d = PH_HUNT;
				left_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			left_q  <= '0;
			free_q  <= '0;
			acc_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			free_q  <= free_d;
			acc_q   <= acc_d;
		end
	end

endmodule

`default_nettype wire
